@@ design/plt_pkg.sv @@
// Shared types and constants for the piecewise-linear table lookup.
// No dependencies; imported by every module of the block.
package plt_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH     = 4;   // front-to-back command queue
  localparam int RES_DEPTH       = 2;   // result queue
  localparam int QW              = 65;  // product and quotient width
  localparam int DW              = 33;  // divisor width
  localparam int Q_CAP_BIT       = 52;  // quotient at or above 2^52 clips

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_BSRCH = 2'd1;
  localparam logic [1:0] FUNC_RIGHT = 2'd2;
  localparam logic [1:0] FUNC_LEFT  = 2'd3;

  localparam logic [2:0] STAT_INTERP = 3'd0;
  localparam logic [2:0] STAT_EXTRAP = 3'd1;
  localparam logic [2:0] STAT_HELD   = 3'd2;
  localparam logic [2:0] STAT_FEW    = 3'd3;
  localparam logic [2:0] STAT_WRITE  = 3'd4;

  typedef enum logic [2:0] {
    OP_WRITE, OP_FEW, OP_BSEARCH, OP_RIGHT, OP_LEFT
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [7:0]         index;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] qx;
  } cmd_t;

  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  status;
    logic [7:0]  cursor;
    logic        sat;
  } res_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_BS_RD, ST_BS_CMP, ST_BS_END,
    ST_SR_RD, ST_SR_CMP, ST_SL0_RD, ST_SL0_CMP, ST_SL_RD, ST_SL_CMP,
    ST_HOLD_RD, ST_HOLD_LAT,
    ST_IP_RD1, ST_IP_RD2, ST_IP_LAT, ST_IP_PREP, ST_IP_MUL, ST_IP_START,
    ST_IP_DIV, ST_IP_FIN, ST_OUT
  } state_t;

endpackage

@@ design/plt_front.sv @@
// Front end: accepts items, classifies them and queues commands for the back end.
// Depends on plt_pkg.
module plt_front #(
  parameter int TABLE_DEPTH = plt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [1:0]                        func,
  input  logic [7:0]                        point_index,
  input  logic signed [31:0]                point_x,
  input  logic signed [31:0]                point_y,
  input  logic signed [31:0]                query_x,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0]  n,
  output logic                              cmd_valid,
  input  logic                              cmd_ready,
  output plt_pkg::cmd_t                     cmd
);
  import plt_pkg::*;

  localparam int NW = $clog2(TABLE_DEPTH + 1);
  localparam int PW = $clog2(QUEUE_DEPTH);

  cmd_t          q [QUEUE_DEPTH];
  logic [PW-1:0] wp, rp;
  logic [PW:0]   count;
  cmd_t          incoming;
  logic          do_push, do_pop;

  always_comb begin
    incoming.index = point_index;
    incoming.px    = point_x;
    incoming.py    = point_y;
    incoming.qx    = query_x;
    if (func == FUNC_WRITE) begin
      incoming.op = OP_WRITE;
    end else if (n < NW'(2)) begin
      incoming.op = OP_FEW;
    end else begin
      case (func)
        FUNC_BSRCH: incoming.op = OP_BSEARCH;
        FUNC_RIGHT: incoming.op = OP_RIGHT;
        default:    incoming.op = OP_LEFT;
      endcase
    end
  end

  assign full      = (count == (PW+1)'(QUEUE_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = q[rp];
  assign do_push   = push && !full;
  assign do_pop    = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wp] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (do_push) wp <= wp + PW'(1);
      if (do_pop)  rp <= rp + PW'(1);
      case ({do_push, do_pop})
        2'b10:   count <= count + (PW+1)'(1);
        2'b01:   count <= count - (PW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ design/plt_div.sv @@
// Restoring divider, one quotient bit per cycle, unsigned.
// Depends on plt_pkg for widths.
module plt_div (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [plt_pkg::QW-1:0] dividend,
  input  logic [plt_pkg::DW-1:0] divisor,
  output logic                   done,
  output logic [plt_pkg::QW-1:0] quot
);
  import plt_pkg::*;

  localparam int CNW = $clog2(QW + 1);

  logic [CNW-1:0] cnt;
  logic           active;
  logic [DW-1:0]  rem, den;
  logic [QW-1:0]  qd;
  logic [DW:0]    rem_sh;
  logic           fits;

  assign rem_sh = {rem, qd[QW-1]};
  assign fits   = (rem_sh >= {1'b0, den});
  assign quot   = qd;

  always_ff @(posedge clk) begin
    if (start) begin
      qd  <= dividend;
      den <= divisor;
      rem <= '0;
    end else if (active) begin
      rem <= fits ? DW'(rem_sh - {1'b0, den}) : DW'(rem_sh);
      qd  <= {qd[QW-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= CNW'(QW);
      end else if (active) begin
        cnt <= cnt - CNW'(1);
        if (cnt == CNW'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

@@ design/plt_back.sv @@
// Back end: breakpoint memory, search/scan sequencer, interpolation and result queue.
// Depends on plt_pkg and plt_div.
module plt_back #(
  parameter int TABLE_DEPTH = plt_pkg::TABLE_DEPTH_DEF,
  parameter int VALUE_WIDTH = plt_pkg::VALUE_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0]  n,
  input  logic                              cmd_valid,
  output logic                              cmd_ready,
  input  plt_pkg::cmd_t                     cmd,
  output logic                              res_empty,
  input  logic                              res_pop,
  output plt_pkg::res_t                     res
);
  import plt_pkg::*;

  localparam int NW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int RW = $clog2(RES_DEPTH);
  localparam logic signed [63:0] HI = (64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] LO = -HI - 64'sd1;

  state_t state, state_next;
  cmd_t   cur;

  // breakpoint memory, {x, y} per entry
  logic [63:0]          tab [TABLE_DEPTH];
  logic [63:0]          rd;
  logic [IW-1:0]        raddr;
  logic                 we;
  logic signed [31:0]   rd_x, rd_y;

  logic [NW-1:0]  lo, cnt, step, i, m;
  logic [IW-1:0]  c, i1, i2, cursor, cc;
  logic [NW:0]    cc2;
  logic [NW-1:0]  mm;
  logic [2:0]     stat;
  logic           first, below, lt;

  logic signed [31:0] x1, y1, x2, y2, rv;
  logic               rsat, neg;
  logic [DW-1:0]      a, b, den;
  logic [QW-1:0]      prod;
  logic [2*DW-1:0]    prod_full;

  logic signed [32:0] dx, dy, dd, mid_s, mid;

  logic               div_start, div_done;
  logic [QW-1:0]      div_q;
  logic               big;
  logic signed [63:0] y1e, qe, r, clipped;
  logic               clip_sat;

  res_t          rq [RES_DEPTH];
  logic [RW-1:0] rwp, rrp;
  logic [RW:0]   rcnt;
  logic          res_full, res_push;

  function automatic logic [DW-1:0] mag(input logic signed [32:0] d);
    return d[32] ? DW'(-d) : DW'(d);
  endfunction

  assign rd_x  = rd[63:32];
  assign rd_y  = rd[31:0];
  assign step  = cnt >> 1;
  assign below = cur.qx < rd_x;
  assign lt    = rd_x < cur.qx;
  assign cc    = (NW'(cursor) < n) ? cursor : IW'(n - NW'(1));
  assign cc2   = (NW+1)'(cc) + (NW+1)'(2);
  assign mm    = (cc2 < {1'b0, n}) ? NW'(cc2) : n;

  always_ff @(posedge clk) begin
    if (we) tab[IW'(cmd.index)] <= {cmd.px, cmd.py};
    rd <= tab[raddr];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            OP_BSEARCH: state_next = ST_BS_RD;
            OP_RIGHT:   state_next = ST_SR_RD;
            OP_LEFT:    state_next = ST_SL0_RD;
            default:    state_next = ST_OUT;
          endcase
        end
      end
      ST_BS_RD:  state_next = ST_BS_CMP;
      ST_BS_CMP: begin
        if ((lt ? cnt - step - NW'(1) : step) == '0) state_next = ST_BS_END;
        else state_next = ST_BS_RD;
      end
      ST_BS_END: state_next = ST_IP_RD1;
      ST_SR_RD:  state_next = ST_SR_CMP;
      ST_SR_CMP: begin
        if (below) state_next = (i == NW'(c)) ? ST_OUT : ST_IP_RD1;
        else if (i + NW'(1) == n) state_next = ST_IP_RD1;
        else state_next = ST_SR_RD;
      end
      ST_SL0_RD:  state_next = ST_SL0_CMP;
      ST_SL0_CMP: state_next = below ? ST_IP_RD1 : ST_SL_RD;
      ST_SL_RD:   state_next = ST_SL_CMP;
      ST_SL_CMP: begin
        if (below) state_next = ST_IP_RD1;
        else if (i + NW'(1) == m) state_next = ST_HOLD_RD;
        else state_next = ST_SL_RD;
      end
      ST_HOLD_RD:  state_next = ST_HOLD_LAT;
      ST_HOLD_LAT: state_next = ST_OUT;
      ST_IP_RD1:   state_next = ST_IP_RD2;
      ST_IP_RD2:   state_next = ST_IP_LAT;
      ST_IP_LAT:   state_next = ST_IP_PREP;
      ST_IP_PREP:  state_next = (dd == '0) ? ST_OUT : ST_IP_MUL;
      ST_IP_MUL:   state_next = ST_IP_START;
      ST_IP_START: state_next = ST_IP_DIV;
      ST_IP_DIV:   state_next = div_done ? ST_IP_FIN : ST_IP_DIV;
      ST_IP_FIN:   state_next = ST_OUT;
      ST_OUT:      state_next = res_full ? ST_OUT : ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    cmd_ready = (state == ST_IDLE);
    we        = (state == ST_IDLE) && cmd_valid && (cmd.op == OP_WRITE) &&
                (int'(cmd.index) < TABLE_DEPTH);
    div_start = (state == ST_IP_START);
    res_push  = (state == ST_OUT) && !res_full;
    case (state)
      ST_BS_RD:   raddr = IW'(lo + step);
      ST_SR_RD:   raddr = IW'(i);
      ST_SL_RD:   raddr = IW'(i);
      ST_HOLD_RD: raddr = c;
      ST_IP_RD1:  raddr = i1;
      ST_IP_RD2:  raddr = i2;
      default:    raddr = '0;
    endcase
  end

  // interpolation arithmetic
  always_comb begin
    dx    = 33'(cur.qx) - 33'(x1);
    dy    = 33'(y2) - 33'(y1);
    dd    = 33'(x2) - 33'(x1);
    mid_s = 33'(y1) + 33'(y2);
    mid   = mid_s[32] ? (mid_s + 33'sd1) >>> 1 : mid_s >>> 1;
  end

  assign prod_full = a * b;

  always_comb begin
    big      = |div_q[QW-1:Q_CAP_BIT];
    y1e      = 64'(y1);
    qe       = signed'({{(64-Q_CAP_BIT){1'b0}}, div_q[Q_CAP_BIT-1:0]});
    r        = neg ? y1e - qe : y1e + qe;
    clip_sat = 1'b1;
    if (big)           clipped = neg ? LO : HI;
    else if (r > HI)   clipped = HI;
    else if (r < LO)   clipped = LO;
    else begin
      clipped  = r;
      clip_sat = 1'b0;
    end
  end

  plt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (den),
    .done     (div_done),
    .quot     (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // datapath and cursor
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            cur  <= cmd;
            rv   <= '0;
            rsat <= 1'b0;
            case (cmd.op)
              OP_WRITE: stat <= STAT_WRITE;
              OP_FEW:   stat <= STAT_FEW;
              OP_BSEARCH: begin
                lo    <= '0;
                cnt   <= n;
                first <= 1'b0;
              end
              OP_RIGHT: begin
                c      <= cc;
                cursor <= cc;
                i      <= NW'(cc);
                first  <= 1'b0;
              end
              default: begin
                c      <= cc;
                cursor <= cc;
                m      <= mm;
                first  <= 1'b0;
              end
            endcase
          end
        end
        ST_BS_CMP: begin
          if (lt) begin
            lo  <= lo + step + NW'(1);
            cnt <= cnt - step - NW'(1);
          end else begin
            cnt <= step;
          end
        end
        ST_BS_END: begin
          if (lo == '0) begin
            i1     <= '0;
            i2     <= IW'(1);
            cursor <= '0;
            first  <= 1'b1;
            stat   <= STAT_INTERP;
          end else if (lo == n) begin
            i1     <= IW'(n - NW'(2));
            i2     <= IW'(n - NW'(1));
            cursor <= IW'(n - NW'(1));
            stat   <= STAT_EXTRAP;
          end else begin
            i1     <= IW'(lo - NW'(1));
            i2     <= IW'(lo);
            cursor <= IW'(lo - NW'(1));
            stat   <= STAT_INTERP;
          end
        end
        ST_SR_CMP: begin
          if (below) begin
            if (i == NW'(c)) begin
              rv   <= rd_y;
              stat <= STAT_HELD;
            end else begin
              i1     <= IW'(i - NW'(1));
              i2     <= IW'(i);
              cursor <= IW'(i - NW'(1));
              stat   <= STAT_INTERP;
            end
          end else if (i + NW'(1) == n) begin
            i1     <= IW'(n - NW'(2));
            i2     <= IW'(n - NW'(1));
            cursor <= IW'(n - NW'(1));
            stat   <= STAT_EXTRAP;
          end else begin
            i <= i + NW'(1);
          end
        end
        ST_SL0_CMP: begin
          if (below) begin
            i1     <= '0;
            i2     <= IW'(1);
            cursor <= '0;
            stat   <= STAT_EXTRAP;
          end else begin
            i <= NW'(1);
          end
        end
        ST_SL_CMP: begin
          if (below) begin
            i1     <= IW'(i - NW'(1));
            i2     <= IW'(i);
            cursor <= IW'(i - NW'(1));
            stat   <= STAT_INTERP;
          end else begin
            i <= i + NW'(1);
          end
        end
        ST_HOLD_LAT: begin
          rv   <= rd_y;
          stat <= STAT_HELD;
        end
        ST_IP_RD2: begin
          x1 <= rd_x;
          y1 <= rd_y;
        end
        ST_IP_LAT: begin
          x2 <= rd_x;
          y2 <= rd_y;
          // lower-bound hit at the first point: below it is extrapolation
          if (first) stat <= (cur.qx < x1) ? STAT_EXTRAP : STAT_INTERP;
        end
        ST_IP_PREP: begin
          if (dd == '0) begin
            if (cur.qx < x1)      rv <= y1;
            else if (cur.qx > x2) rv <= y2;
            else                  rv <= mid[31:0];
          end else begin
            a   <= mag(dx);
            b   <= mag(dy);
            den <= mag(dd);
            neg <= dx[32] ^ dy[32] ^ dd[32];
          end
        end
        ST_IP_MUL: prod <= prod_full[QW-1:0];
        ST_IP_FIN: begin
          rv   <= clipped[31:0];
          rsat <= clip_sat;
        end
        default: ;
      endcase
    end
  end

  // result queue
  assign res_full  = (rcnt == (RW+1)'(RES_DEPTH));
  assign res_empty = (rcnt == '0);
  assign res       = rq[rrp];

  always_ff @(posedge clk) begin
    if (res_push) begin
      rq[rwp] <= '{value: rv, status: stat, cursor: 8'(cursor), sat: rsat};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rwp  <= '0;
      rrp  <= '0;
      rcnt <= '0;
    end else begin
      if (res_push) rwp <= rwp + RW'(1);
      if (res_pop && !res_empty) rrp <= rrp + RW'(1);
      case ({res_push, res_pop && !res_empty})
        2'b10:   rcnt <= rcnt + (RW+1)'(1);
        2'b01:   rcnt <= rcnt - (RW+1)'(1);
        default: rcnt <= rcnt;
      endcase
    end
  end

endmodule

@@ design/piecewise_linear_table_lookup.sv @@
// Top level of the piecewise-linear table lookup: APB register, front and back ends.
// Depends on plt_pkg, plt_front, plt_back.
//
// Breakpoints (signed Q16.16) are written as items with func 0 and queried with
// func 1 (lower-bound binary search), 2 (scan right from the cursor) or 3 (scan
// left up to the cursor); every item yields exactly one result. Items enter a
// four-deep command queue and are carried out one at a time by the back end,
// whose breakpoint memory has one registered read port: a write or a query on a
// table of fewer than two points goes straight to the result queue; a binary
// search makes at most log2(n)+1 probes, each a read and a compare, and a scan
// reads and compares each entry it visits; an interpolation then adds two reads,
// a registered product and the bit-serial 65-bit divider. Equal neighbouring x
// skip the divider. Results wait in a two-deep queue, so the back end runs on
// while a result is not yet taken. The table needs no clearing after reset;
// entries must be written before they are read. point_count sits at address 0
// and is to be written only while the block is idle.
module piecewise_linear_table_lookup #(
  parameter int TABLE_DEPTH = plt_pkg::TABLE_DEPTH_DEF,
  parameter int VALUE_WIDTH = plt_pkg::VALUE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // item input
  input  logic               push,
  output logic               full,
  input  logic [1:0]         func,
  input  logic [7:0]         point_index,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] query_x,
  // results
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] value,
  output logic [2:0]         status,
  output logic [7:0]         cursor,
  output logic               saturated,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import plt_pkg::*;

  localparam int NW   = $clog2(TABLE_DEPTH + 1);
  localparam int CMPW = (NW > 9) ? NW : 9;

  logic [8:0]    point_count;
  logic [NW-1:0] n;
  logic          cmd_valid, cmd_ready;
  cmd_t          cmd;
  res_t          res;

  // register file: only point_count, at byte address 0
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {23'b0, point_count} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      point_count <= pwdata[8:0];
    end
  end

  // effective count, capped at the table depth
  assign n = (CMPW'(point_count) >= CMPW'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH)
                                                        : NW'(point_count);

  plt_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .func        (func),
    .point_index (point_index),
    .point_x     (point_x),
    .point_y     (point_y),
    .query_x     (query_x),
    .n           (n),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd)
  );

  plt_back #(.TABLE_DEPTH(TABLE_DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .n         (n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_empty (empty),
    .res_pop   (pop),
    .res       (res)
  );

  assign value     = res.value;
  assign status    = res.status;
  assign cursor    = res.cursor;
  assign saturated = res.sat;

endmodule

@@ design/plt_checker.sv @@
// Port-level checks for piecewise_linear_table_lookup, attached by bind.
// Depends on plt_pkg for status codes.
module plt_checker (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic [31:0] value,
  input logic [2:0]  status,
  input logic        saturated
);
  import plt_pkg::*;

  // nothing to deliver straight after reset
  a_reset_empty: assert property (@(posedge clk) $fell(rst) |-> empty)
    else $error("result shown after reset");

  // writes and short-table queries return zero and never clip
  a_write_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && (status == STAT_WRITE || status == STAT_FEW)) |->
      (value == 32'd0 && !saturated))
    else $error("write or short-table result not zero");

  // only interpolated or extrapolated results can clip
  a_sat_path: assert property (@(posedge clk) disable iff (rst)
    (!empty && saturated) |-> (status == STAT_INTERP || status == STAT_EXTRAP))
    else $error("saturation on a held result");

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(value) && $stable(status)))
    else $error("waiting result changed");

endmodule

bind piecewise_linear_table_lookup plt_checker u_plt_checker (.*);
